// File: sv/acs_pkg.sv
// Shared types and constants of the affinity chunk scheduler.
`timescale 1ns / 1ps

package acs_pkg;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ITERATIONS = 1'b1;

    // Register widths and reset values.
    localparam int NUM_WORKERS_W = 5;
    localparam int TOTAL_ITER_W  = 11;
    localparam logic [NUM_WORKERS_W-1:0] NUM_WORKERS_RST = 5'd4;
    localparam logic [TOTAL_ITER_W-1:0]  TOTAL_ITER_RST  = 11'd729;

    // Operation codes of an input request.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // One input request.
    typedef struct packed {
        logic       op;
        logic [3:0] worker;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [9:0]  chunk_lo;
        logic [10:0] chunk_hi;
        logic [3:0]  owner;
        logic        granted;
        logic        all_done;
    } t_out_item;

endpackage

// File: sv/affinity_chunk_scheduler.sv
// Top level of the affinity chunk scheduler: sequencer, configuration and result register.
`timescale 1ns / 1ps

// Loop-iteration scheduler. A start request splits the iteration space into one contiguous
// range of ceil(total/N) iterations for each of the N effective workers, clipped at the
// total; a chunk request from a worker below N hands out ceil(remaining/N) iterations from
// the front of its own range, or steals that share from the worker with the most left
// (lowest index on a tie); one from a worker at or above N gets no chunk. Every result
// carries all_done. One request is handled at a time: the input stalls from acceptance
// until the result is in the output register, which may still wait on the far side while
// the next request is taken. The time is set by the shared bit-serial divider, one
// quotient bit per cycle, and by the single read port of the worker table, which is
// walked one entry per cycle. The table comes out of reset empty through per-entry valid
// bits, so no clearing pass is needed.
module affinity_chunk_scheduler #(
    parameter int MAX_WORKERS    = 16,
    parameter int MAX_ITERATIONS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  acs_pkg::t_in_item                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output acs_pkg::t_out_item               o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [acs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import acs_pkg::*;

    // Iteration count never exceeds what the configuration register can hold.
    localparam int TOT_REG_MAX = (1 << TOTAL_ITER_W) - 1;
    localparam int MAXT = (MAX_ITERATIONS < TOT_REG_MAX) ? MAX_ITERATIONS : TOT_REG_MAX;
    localparam int CW   = $clog2(MAXT + 1);
    localparam int EW   = 2 * CW;
    localparam int AW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int IW   = $clog2(MAX_WORKERS + 1);
    localparam int DW   = $clog2(MAXT + MAX_WORKERS);
    localparam int SW   = $clog2(2 * MAXT + MAX_WORKERS + 1);
    localparam int CMPW = (IW > 4) ? IW : 4;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_PART_DIV  = 8'b0000_0010,
        ST_PART_WR   = 8'b0000_0100,
        ST_REQ_CHK   = 8'b0000_1000,
        ST_SCAN      = 8'b0001_0000,
        ST_GRANT_DIV = 8'b0010_0000,
        ST_ASCAN     = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [NUM_WORKERS_W-1:0] r_nw_cfg;
    logic [TOTAL_ITER_W-1:0]  r_tot_cfg;
    logic [IW-1:0]            r_idx, n_idx;
    logic                     r_pend, n_pend;
    logic [AW-1:0]            r_pidx, n_pidx;
    logic [AW-1:0]            r_src, n_src;
    logic [CW-1:0]            r_end, n_end;
    logic [CW-1:0]            r_rem, n_rem;
    logic                     r_found, n_found;
    logic                     r_any, n_any;
    logic [CW-1:0]            r_ipt, n_ipt;
    logic [SW-1:0]            r_s, n_s;
    logic [CW-1:0]            r_lo, n_lo;
    logic [CW-1:0]            r_hi, n_hi;
    logic                     r_granted, n_granted;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    logic                     in_accept;
    logic                     cfg_we;
    logic                     out_free;
    logic [IW-1:0]            nw_eff;
    logic [CW-1:0]            tot_eff;
    logic [CMPW-1:0]          w_ext;
    logic [CMPW-1:0]          nw_ext;

    logic                     tbl_clr;
    logic                     tbl_wr_en;
    logic [AW-1:0]            tbl_wr_addr;
    logic [EW-1:0]            tbl_wr_data;
    logic                     tbl_rd_en;
    logic [AW-1:0]            tbl_rd_addr;
    logic [EW-1:0]            tbl_rd_data;
    logic [CW-1:0]            rd_end;
    logic [CW-1:0]            rd_rem;

    logic                     div_start;
    logic [DW-1:0]            div_num;
    logic                     div_done;
    logic [DW-1:0]            div_quo;
    logic [CW-1:0]            share;

    logic [SW-1:0]            pe_next;
    logic [SW-1:0]            pe_tot;
    logic [SW-1:0]            pe_e;
    logic [CW-1:0]            pe_end;
    logic [CW-1:0]            pe_rem;

    // Handshakes.
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Effective worker and iteration counts, clamped to the supported range.
    always_comb begin
        if (r_nw_cfg == '0) begin
            nw_eff = IW'(1);
        end else if (32'(r_nw_cfg) > MAX_WORKERS) begin
            nw_eff = IW'(MAX_WORKERS);
        end else begin
            nw_eff = IW'(r_nw_cfg);
        end
        if (32'(r_tot_cfg) > MAXT) begin
            tot_eff = CW'(MAXT);
        end else begin
            tot_eff = CW'(r_tot_cfg);
        end
        w_ext  = CMPW'(i_in.worker);
        nw_ext = CMPW'(nw_eff);
    end

    // Table entry fields: range end in the upper half, remaining count in the lower.
    assign rd_end = tbl_rd_data[EW-1:CW];
    assign rd_rem = tbl_rd_data[CW-1:0];
    assign share  = CW'(div_quo);

    // Range of the worker being written during partitioning, clipped at the total.
    always_comb begin
        pe_next = r_s + SW'(r_ipt);
        pe_tot  = SW'(tot_eff);
        pe_e    = (pe_next > pe_tot) ? pe_tot : pe_next;
        if (r_s >= pe_tot) begin
            pe_end = tot_eff;
            pe_rem = '0;
        end else begin
            pe_end = CW'(pe_e);
            pe_rem = CW'(pe_e - r_s);
        end
    end

    acs_table #(
        .WIDTH(EW),
        .DEPTH(MAX_WORKERS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (tbl_clr),
        .i_wr_en  (tbl_wr_en),
        .i_wr_addr(tbl_wr_addr),
        .i_wr_data(tbl_wr_data),
        .i_rd_en  (tbl_rd_en),
        .i_rd_addr(tbl_rd_addr),
        .o_rd_data(tbl_rd_data)
    );

    acs_div #(
        .DW(DW),
        .VW(IW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (nw_eff),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_src       = r_src;
        n_end       = r_end;
        n_rem       = r_rem;
        n_found     = r_found;
        n_any       = r_any;
        n_ipt       = r_ipt;
        n_s         = r_s;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_granted   = r_granted;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        tbl_clr     = 1'b0;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_src;
        tbl_wr_data = {r_end, r_rem};
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = r_idx[AW-1:0];
        div_start   = 1'b0;
        div_num     = DW'(r_rem) + DW'(nw_eff) - DW'(1);

        // Both table walks issue one read per cycle until every worker has been read.
        if ((r_state == ST_SCAN || r_state == ST_ASCAN) && (r_idx < nw_eff)) begin
            tbl_rd_en = 1'b1;
            n_pend    = 1'b1;
            n_pidx    = r_idx[AW-1:0];
            n_idx     = r_idx + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_granted = 1'b0;
                    if (i_in.op == OP_START) begin
                        tbl_clr   = 1'b1;
                        div_start = 1'b1;
                        div_num   = DW'(tot_eff) + DW'(nw_eff) - DW'(1);
                        n_state   = ST_PART_DIV;
                    end else if (w_ext < nw_ext) begin
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = AW'(i_in.worker);
                        n_src       = AW'(i_in.worker);
                        n_state     = ST_REQ_CHK;
                    end else begin
                        n_idx   = '0;
                        n_any   = 1'b0;
                        n_state = ST_ASCAN;
                    end
                end
            end

            // Wait for the per-worker range size.
            ST_PART_DIV: begin
                if (div_done) begin
                    n_ipt   = CW'(div_quo);
                    n_s     = '0;
                    n_idx   = '0;
                    n_state = ST_PART_WR;
                end
            end

            // Write one worker range per cycle.
            ST_PART_WR: begin
                if (r_idx < nw_eff) begin
                    tbl_wr_en   = 1'b1;
                    tbl_wr_addr = r_idx[AW-1:0];
                    tbl_wr_data = {pe_end, pe_rem};
                    n_s         = pe_next;
                    n_idx       = r_idx + 1'b1;
                end else begin
                    n_idx   = '0;
                    n_any   = 1'b0;
                    n_state = ST_ASCAN;
                end
            end

            // Own entry has arrived: serve from it or fall back to stealing.
            ST_REQ_CHK: begin
                if (rd_rem != '0) begin
                    n_rem     = rd_rem;
                    n_end     = rd_end;
                    div_start = 1'b1;
                    div_num   = DW'(rd_rem) + DW'(nw_eff) - DW'(1);
                    n_state   = ST_GRANT_DIV;
                end else begin
                    n_idx   = '0;
                    n_rem   = '0;
                    n_found = 1'b0;
                    n_state = ST_SCAN;
                end
            end

            // Search for the worker with the most left; strict compare keeps the lowest index.
            ST_SCAN: begin
                if (r_pend && (rd_rem > r_rem)) begin
                    n_rem   = rd_rem;
                    n_end   = rd_end;
                    n_src   = r_pidx;
                    n_found = 1'b1;
                end
                if (!(r_idx < nw_eff) && !r_pend) begin
                    n_idx = '0;
                    if (r_found) begin
                        div_start = 1'b1;
                        n_state   = ST_GRANT_DIV;
                    end else begin
                        n_any   = 1'b0;
                        n_state = ST_ASCAN;
                    end
                end
            end

            // Take the share from the front of the source range.
            ST_GRANT_DIV: begin
                if (div_done) begin
                    n_lo        = r_end - r_rem;
                    n_hi        = r_end - r_rem + share;
                    n_granted   = 1'b1;
                    tbl_wr_en   = 1'b1;
                    tbl_wr_addr = r_src;
                    tbl_wr_data = {r_end, r_rem - share};
                    n_idx       = '0;
                    n_any       = 1'b0;
                    n_state     = ST_ASCAN;
                end
            end

            // Check whether any worker still has iterations left.
            ST_ASCAN: begin
                if (r_pend && (rd_rem != '0)) begin
                    n_any = 1'b1;
                end
                if (!(r_idx < nw_eff) && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end

            // Hand the result to the output register once it is free.
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.chunk_lo = r_granted ? 10'(r_lo) : '0;
                    n_out.chunk_hi = r_granted ? 11'(r_hi) : '0;
                    n_out.owner    = r_granted ? 4'(r_src) : '0;
                    n_out.granted  = r_granted;
                    n_out.all_done = !r_any;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_nw_cfg    <= NUM_WORKERS_RST;
            r_tot_cfg   <= TOTAL_ITER_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_WORKERS:      r_nw_cfg  <= i_cfg_data[NUM_WORKERS_W-1:0];
                    CFG_TOTAL_ITERATIONS: r_tot_cfg <= i_cfg_data[TOTAL_ITER_W-1:0];
                    default: begin
                        r_nw_cfg <= r_nw_cfg;
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_src     <= n_src;
        r_end     <= n_end;
        r_rem     <= n_rem;
        r_found   <= n_found;
        r_any     <= n_any;
        r_ipt     <= n_ipt;
        r_s       <= n_s;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_granted <= n_granted;
        r_out     <= n_out;
    end

`ifndef ASSERT_OFF
    // An accepted request always starts a sequence.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_PART_DIV || r_state == ST_GRANT_DIV))
        else $error("divider finished outside a divide wait");

    // A granted chunk is never empty.
    a_chunk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_granted) |-> (r_hi > r_lo))
        else $error("granted chunk is empty");

    // A result without a grant carries zero chunk fields.
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.granted) |->
        (o_out.chunk_lo == '0 && o_out.chunk_hi == '0 && o_out.owner == '0))
        else $error("chunk fields set on a result without a grant");
`endif

endmodule

// File: sv/acs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module acs_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/acs_table.sv
// Per-worker table of range end and remaining count, with valid bits that clear at once.
`timescale 1ns / 1ps

module acs_table #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_clr,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic             r_vld [DEPTH];
    logic             r_rd_vld;
    logic [WIDTH-1:0] ram_q;

    acs_ram #(
        .WIDTH(WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_wr_en),
        .i_wr_addr(i_wr_addr),
        .i_wr_data(i_wr_data),
        .i_rd_en  (i_rd_en),
        .i_rd_addr(i_rd_addr),
        .o_rd_data(ram_q)
    );

    // Valid bits: a clear drops every entry, a write in the same cycle still marks its entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_clr) begin
                for (int i = 0; i < DEPTH; i++) begin
                    r_vld[i] <= 1'b0;
                end
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Valid bit follows the read data through the same register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // An entry that was never written since the last clear reads as zero.
    assign o_rd_data = r_rd_vld ? ram_q : '0;

endmodule

// File: sv/acs_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module acs_div #(
    parameter int DW = 11,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_num;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_den;

    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;
    logic [DW:0]     shifted;

    // One trial subtraction of the partial remainder.
    always_comb begin
        trial   = {r_rem, r_num[DW-1]};
        diff    = trial - {1'b0, r_den};
        ge      = (trial >= {1'b0, r_den});
        shifted = {r_num, ge};
    end

    // Control: busy while the quotient bits are produced, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_num <= shifted[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule
